// ===== rtl/irdf_pkg.sv =====
// Package: widths, header offsets and the record length helper for the record delete filter.
package irdf_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned NAME_W  = 16;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned POS_W   = 33;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [NAME_W-1:0]  name_len_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [POS_W-1:0]   pos_t;

  // Header layout.
  localparam pos_t HEADER_BYTES   = pos_t'(24);
  localparam pos_t HEADER_LAST    = pos_t'(23);
  localparam pos_t NAME_LO_POS    = pos_t'(10);
  localparam pos_t NAME_HI_POS    = pos_t'(11);
  localparam pos_t SIZE_FIRST_POS = pos_t'(16);
  localparam pos_t SIZE_LAST_POS  = pos_t'(19);

  // Whole record length: header plus name plus payload, fits in 33 bits.
  function automatic pos_t record_len(input name_len_t name_len, input size_t size);
    record_len = HEADER_BYTES + pos_t'(name_len) + pos_t'(size);
  endfunction

endpackage

// ===== rtl/irdf_if.sv =====
// Interfaces: input byte channel, result byte channel and configuration write channel.
interface irdf_in_if;
  logic                 valid;
  logic                 ready;
  irdf_pkg::byte_t      in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface irdf_out_if;
  logic                 valid;
  logic                 ready;
  irdf_pkg::byte_t      out_byte;
  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface irdf_cfg_if;
  logic                 valid;
  logic                 ready;
  irdf_pkg::index_t     delete_index;
  modport source (output valid, output delete_index, input ready);
  modport sink   (input valid, input delete_index, output ready);
endinterface

// ===== rtl/indexed_record_delete_filter.sv =====
// Top level: byte stream filter that drops the one record whose number matches delete_index.
//
//   channel  dir  payload             notes
//   in_s     in   in_byte [7:0]       record stream, one byte per item
//   out_s    out  out_byte [7:0]      passed bytes, dropped bytes give no item
//   cfg_s    in   delete_index [31:0] always ready, write only while idle
//
// Each byte sits in the input register and is parsed as it leaves; a passed
// byte then waits in the result register. One item per cycle is sustained
// while out_s is ready; the record length add and compare on the 33-bit
// position sets the cycle time. Reset (rst_n low, synchronous) clears
// both stages, the parser state and delete_index. A stalled result holds the
// input stage only when that stage carries a byte that will pass.
module indexed_record_delete_filter (
  input  logic               clk,
  input  logic               rst_n,
  irdf_in_if.sink            in_s,
  irdf_out_if.source         out_s,
  irdf_cfg_if.sink           cfg_s
);
  import irdf_pkg::*;

  // Configuration register.
  index_t    delete_index_r;

  // Input stage.
  logic      in_vld_r, in_vld_nxt;
  byte_t     in_byte_r;

  // Parser state.
  index_t    rec_num_r, rec_num_nxt;
  pos_t      byte_pos_r, byte_pos_nxt;
  name_len_t name_len_r, name_len_nxt;
  size_t     size_r, size_nxt;
  logic      dropping_r, dropping_nxt;
  logic      done_r, done_nxt;

  // Result stage.
  logic      out_vld_r, out_vld_nxt;
  byte_t     out_byte_r;

  logic      drop_now;
  logic      pass;
  logic      rec_end;
  logic      adv;
  logic      take_in;
  logic [POS_W:0] pos_inc;

  assign cfg_s.ready = 1'b1;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delete_index_r <= '0;
    end else if (cfg_s.valid) begin
      delete_index_r <= cfg_s.delete_index;
    end
  end

  // Pass decision for the byte in the input stage.
  assign drop_now = (byte_pos_r == '0)
                    ? ((delete_index_r != '0) && (rec_num_r == delete_index_r))
                    : dropping_r;
  assign pass     = done_r || !drop_now;
  assign adv      = in_vld_r && (!pass || !out_vld_r || out_s.ready);
  assign in_s.ready = !in_vld_r || adv;
  assign take_in  = in_s.valid && in_s.ready;

  // Record end: length fields are complete before offset 23, so registered values serve.
  assign pos_inc  = {1'b0, byte_pos_r} + {{POS_W{1'b0}}, 1'b1};
  assign rec_end  = (byte_pos_r >= HEADER_LAST)
                    && (pos_inc >= {1'b0, record_len(name_len_r, size_r)});

  // Parser next state.
  always_comb begin
    rec_num_nxt  = rec_num_r;
    byte_pos_nxt = byte_pos_r;
    name_len_nxt = name_len_r;
    size_nxt     = size_r;
    dropping_nxt = dropping_r;
    done_nxt     = done_r;
    if (adv && !done_r) begin
      dropping_nxt = drop_now;
      if (byte_pos_r == NAME_LO_POS) begin
        name_len_nxt[7:0] = in_byte_r;
      end else if (byte_pos_r == NAME_HI_POS) begin
        name_len_nxt[15:8] = in_byte_r;
      end else if (byte_pos_r >= SIZE_FIRST_POS && byte_pos_r <= SIZE_LAST_POS) begin
        unique case (byte_pos_r[1:0])
          2'd0: size_nxt[7:0]   = in_byte_r;
          2'd1: size_nxt[15:8]  = in_byte_r;
          2'd2: size_nxt[23:16] = in_byte_r;
          2'd3: size_nxt[31:24] = in_byte_r;
          default: size_nxt = size_r;
        endcase
      end
      if (rec_end) begin
        byte_pos_nxt = '0;
        rec_num_nxt  = rec_num_r + index_t'(1);
        if (drop_now) begin
          done_nxt     = 1'b1;
          dropping_nxt = 1'b0;
        end
      end else begin
        byte_pos_nxt = pos_inc[POS_W-1:0];
      end
    end
  end

  // Stage valid bits.
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (take_in) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv && pass) begin
      out_vld_nxt = 1'b1;
    end else if (out_s.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      rec_num_r  <= index_t'(1);
      byte_pos_r <= '0;
      name_len_r <= '0;
      size_r     <= '0;
      dropping_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      in_vld_r   <= in_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      rec_num_r  <= rec_num_nxt;
      byte_pos_r <= byte_pos_nxt;
      name_len_r <= name_len_nxt;
      size_r     <= size_nxt;
      dropping_r <= dropping_nxt;
      done_r     <= done_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_byte_r <= in_s.in_byte;
    end
    if (adv && pass) begin
      out_byte_r <= in_byte_r;
    end
  end

  assign out_s.valid    = out_vld_r;
  assign out_s.out_byte = out_byte_r;

  // Once the dropped record has gone by, nothing is dropped again.
  a_done_not_dropping: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !dropping_r)
    else $error("dropping flag set after deletion finished");

  // A held input-stage byte stays put until it moves on.
  a_in_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> (in_vld_r && $stable(in_byte_r)))
    else $error("input stage byte lost while stalled");

  // The record counter moves only at a record boundary.
  a_rec_num_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_num_nxt != rec_num_r) |-> (adv && rec_end && byte_pos_nxt == '0))
    else $error("record counter changed inside a record");

endmodule
